// ----- sv/pow_pkg.sv -----
// Shared types and constants for the pitch outlier window average block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package pow_pkg;

  // Field widths
  localparam int LAG_W    = 8;
  localparam int AVG_W    = 12;
  localparam int SUM_W    = 12;
  localparam int RUN_W    = 8;
  localparam int FRAC_W   = 4;
  localparam int DVD_W    = SUM_W + FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_SPAN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_SPAN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RISE_FRONT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FALL_FRONT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RISE_BACK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FALL_BACK  = 3'd7;

  // Configuration register file
  typedef struct packed {
    logic [1:0]       front_span;
    logic [1:0]       back_span;
    logic [3:0]       window_len;
    logic [RUN_W-1:0] run_threshold;
    logic [LAG_W-1:0] max_rise_front;
    logic [LAG_W-1:0] max_fall_front;
    logic [LAG_W-1:0] max_rise_back;
    logic [LAG_W-1:0] max_fall_back;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    front_span:     2'd1,
    back_span:      2'd1,
    window_len:     4'd8,
    run_threshold:  8'd9,
    max_rise_front: 8'd20,
    max_fall_front: 8'd20,
    max_rise_back:  8'd20,
    max_fall_back:  8'd22
  };

  // Sequencer to window store controls
  typedef struct packed {
    logic judge;   // write judged lag, fetch leaving entry, update run
    logic accum;   // fold into running sum, advance pointer
  } win_ctl_t;

endpackage

// ----- sv/pow_lag_if.sv -----
// Input channel carrying one pitch lag word.
// Depends on pow_pkg for the lag width.
`timescale 1ns / 1ps

interface pow_lag_if;
  logic                      valid;
  logic                      ready;
  logic [pow_pkg::LAG_W-1:0] lag;

  modport source (output valid, output lag, input ready);
  modport sink   (input valid, input lag, output ready);
endinterface

// ----- sv/pow_res_if.sv -----
// Output channel carrying one window average word.
// Depends on pow_pkg for the average width.
`timescale 1ns / 1ps

interface pow_res_if;
  logic                      valid;
  logic                      ready;
  logic [pow_pkg::AVG_W-1:0] average_q4;
  logic                      average_valid;

  modport source (output valid, output average_q4, output average_valid, input ready);
  modport sink   (input valid, input average_q4, input average_valid, output ready);
endinterface

// ----- sv/pow_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on pow_pkg for index and data widths.
`timescale 1ns / 1ps

interface pow_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pow_pkg::CFG_IDX_W-1:0]  idx;
  logic [pow_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ----- sv/pow_judge.sv -----
// Recent lag shift buffer and outlier judgement of the delayed centre lag.
// Depends on pow_pkg.
`timescale 1ns / 1ps

module pow_judge #(
  parameter int RecentDepth = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic                      judge_i,
  input  logic [pow_pkg::LAG_W-1:0] lag_i,
  input  pow_pkg::cfg_t             cfg_i,
  output logic [pow_pkg::LAG_W-1:0] judged_o
);
  import pow_pkg::*;

  localparam int CW = $clog2(RecentDepth);

  logic [LAG_W-1:0] buf_q [RecentDepth];
  logic             last_rej_q, last_rej_d;
  logic [1:0]       back;
  logic [CW-1:0]    centre;
  logic [LAG_W-1:0] cur, prev, nxt, judged_pre;
  logic             zero_hit, apply, fail_front, fail_back, fail;

  // Effective back span: zero reads as one, limited so the centre keeps
  // an earlier neighbour
  always_comb begin
    back = (cfg_i.back_span == 2'd0) ? 2'd1 : cfg_i.back_span;
    if (int'(back) > RecentDepth - 2) begin
      back = 2'(RecentDepth - 2);
    end
    centre = CW'(RecentDepth - 1) - CW'(back);
  end

  // Tap selection and zero checks, one term per buffer position
  always_comb begin
    cur      = '0;
    prev     = '0;
    nxt      = '0;
    zero_hit = 1'b0;
    for (int j = 0; j < RecentDepth; j++) begin
      if (j == int'(centre)) cur = buf_q[j];
      if (j + 1 == int'(centre)) prev = buf_q[j];
      if (j == int'(centre) + 1) nxt = buf_q[j];
      // later neighbours run up to the newest entry
      if (j > int'(centre) && buf_q[j] == '0) zero_hit = 1'b1;
      // earlier neighbours within the front span
      if (j < int'(centre) && j + int'(cfg_i.front_span) >= int'(centre)
          && buf_q[j] == '0) zero_hit = 1'b1;
    end
  end

  // Jump checks against nearest neighbours
  always_comb begin
    judged_pre = zero_hit ? '0 : cur;
    apply      = (judged_pre != '0) && (prev != '0) && (nxt != '0);
    fail_front = ((cur > prev) && (cur - prev > cfg_i.max_rise_front))
              || ((prev > cur) && (prev - cur > cfg_i.max_fall_front));
    fail_back  = ((cur > nxt) && (cur - nxt > cfg_i.max_rise_back))
              || ((nxt > cur) && (nxt - cur > cfg_i.max_fall_back));
    fail       = (!last_rej_q && fail_front) || fail_back;
    judged_o   = (apply && fail) ? '0 : judged_pre;
    last_rej_d = apply ? (last_rej_q | fail) : 1'b0;
  end

  // Shift buffer, oldest at index zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < RecentDepth; j++) buf_q[j] <= '0;
    end else if (shift_i) begin
      for (int j = 0; j < RecentDepth - 1; j++) buf_q[j] <= buf_q[j+1];
      buf_q[RecentDepth-1] <= lag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rej_q <= 1'b0;
    end else if (judge_i) begin
      last_rej_q <= last_rej_d;
    end
  end

endmodule

// ----- sv/pow_window.sv -----
// Circular store of judged lags with running window sum and run counter.
// Depends on pow_pkg.
`timescale 1ns / 1ps

module pow_window #(
  parameter int WindowDepth = 16,
  parameter int LenW        = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pow_pkg::win_ctl_t         ctl_i,
  input  logic [pow_pkg::LAG_W-1:0] judged_i,
  input  logic [LenW-1:0]           len_i,
  output logic [pow_pkg::SUM_W-1:0] sum_o,
  output logic [pow_pkg::RUN_W-1:0] run_o
);
  import pow_pkg::*;

  localparam int AW = $clog2(WindowDepth);
  localparam int PW = LenW + 1;

  logic [LAG_W-1:0] mem_q [WindowDepth];
  logic [WindowDepth-1:0] vld_q;
  logic [AW-1:0]    ptr_q;
  logic [PW-1:0]    lv_sum;
  logic [AW-1:0]    lv_addr;
  logic [LAG_W-1:0] rd_q, judged_q;
  logic             rd_vld_q;
  logic [SUM_W-1:0] sum_q, leave;
  logic [RUN_W-1:0] run_q;

  // Entry leaving the window: len places behind the write pointer
  always_comb begin
    lv_sum = PW'(ptr_q) + PW'(WindowDepth) - PW'(len_i);
    if (lv_sum >= PW'(WindowDepth)) begin
      lv_sum = lv_sum - PW'(WindowDepth);
    end
    lv_addr = lv_sum[AW-1:0];
    leave   = rd_vld_q ? SUM_W'(rd_q) : '0;
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.judge) begin
      mem_q[ptr_q] <= judged_i;
      rd_q         <= mem_q[lv_addr];
      judged_q     <= judged_i;
    end
  end

  // Written-entry flags; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (ctl_i.judge) begin
      vld_q[ptr_q] <= 1'b1;
      rd_vld_q     <= vld_q[lv_addr];
    end
  end

  // Running sum and pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      ptr_q <= '0;
    end else if (ctl_i.accum) begin
      sum_q <= sum_q + SUM_W'(judged_q) - leave;
      ptr_q <= (ptr_q == AW'(WindowDepth - 1)) ? '0 : ptr_q + AW'(1);
    end
  end

  // Saturating run of non-zero judged lags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (ctl_i.judge) begin
      if (judged_i == '0) begin
        run_q <= '0;
      end else if (run_q != RUN_MAX) begin
        run_q <= run_q + RUN_W'(1);
      end
    end
  end

  assign sum_o = sum_q;
  assign run_o = run_q;

endmodule

// ----- sv/pow_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on pow_pkg for the dividend width.
`timescale 1ns / 1ps

module pow_div #(
  parameter int LenW = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pow_pkg::DVD_W-1:0] dividend_i,
  input  logic [LenW-1:0]           divisor_i,
  output logic                      busy_o,
  output logic [pow_pkg::DVD_W-1:0] quot_o
);
  import pow_pkg::*;

  localparam int NW = $clog2(DVD_W);

  logic            busy_q;
  logic [NW-1:0]   cnt_q;
  logic [DVD_W-1:0] qr_q;
  logic [LenW-1:0] rem_q, dvs_q, rem_d;
  logic [LenW:0]   trial;
  logic            ge;

  // One restoring step
  always_comb begin
    trial = {rem_q, qr_q[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? LenW'(trial - {1'b0, dvs_q}) : trial[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + NW'(1);
      if (cnt_q == NW'(DVD_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qr_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      qr_q  <= {qr_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = qr_q;

endmodule

// ----- sv/pitch_outlier_window_average.sv -----
// Pitch outlier rejection and window average: each lag word yields one result word after
// shift, judge, sum update, divider load, sixteen divider steps and output load in turn; the
// next lag word is accepted in the cycle after the result enters the output register, which
// holds it until taken. Configuration writes are taken in any cycle with ready held high.
// Depends on pow_pkg, the three channel interfaces, pow_judge, pow_window and pow_div.
`timescale 1ns / 1ps

module pitch_outlier_window_average #(
  parameter int RECENT_DEPTH = 6,
  parameter int WINDOW_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pow_lag_if.sink   lag_i,
  pow_res_if.source res_o,
  pow_cfg_if.sink   cfg_i
);
  import pow_pkg::*;

  localparam int LW = ($clog2(WINDOW_DEPTH) > 4) ? $clog2(WINDOW_DEPTH) : 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_JUDGE = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;

  logic [2:0]       state_q, state_d;
  cfg_t             cfg_q;
  logic [LW-1:0]    wl;
  logic [LAG_W-1:0] judged;
  logic [SUM_W-1:0] sum;
  logic [RUN_W-1:0] run;
  win_ctl_t         win_ctl;
  logic             in_acc, div_start, div_busy, out_free, out_load, avg_ok;
  logic [DVD_W-1:0] quot;
  logic [AVG_W-1:0] avg_sat;
  logic             res_valid_q;
  logic [AVG_W-1:0] avg_q;
  logic             avg_vld_q;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        CFG_FRONT_SPAN:     cfg_q.front_span     <= cfg_i.data[1:0];
        CFG_BACK_SPAN:      cfg_q.back_span      <= cfg_i.data[1:0];
        CFG_WINDOW_LEN:     cfg_q.window_len     <= cfg_i.data[3:0];
        CFG_RUN_THRESHOLD:  cfg_q.run_threshold  <= cfg_i.data;
        CFG_MAX_RISE_FRONT: cfg_q.max_rise_front <= cfg_i.data;
        CFG_MAX_FALL_FRONT: cfg_q.max_fall_front <= cfg_i.data;
        CFG_MAX_RISE_BACK:  cfg_q.max_rise_back  <= cfg_i.data;
        CFG_MAX_FALL_BACK:  cfg_q.max_fall_back  <= cfg_i.data;
      endcase
    end
  end

  // Effective window length, one to depth less one
  always_comb begin
    wl = LW'(cfg_q.window_len);
    if (cfg_q.window_len == 4'd0) begin
      wl = LW'(1);
    end else if (wl > LW'(WINDOW_DEPTH - 1)) begin
      wl = LW'(WINDOW_DEPTH - 1);
    end
  end

  // Sequencer
  assign lag_i.ready = (state_q == ST_IDLE);
  assign in_acc      = lag_i.valid && lag_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;
  assign win_ctl     = '{judge: (state_q == ST_JUDGE), accum: (state_q == ST_SUM)};
  assign div_start   = (state_q == ST_LOAD);
  assign out_load    = (state_q == ST_DIV) && !div_busy && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_JUDGE;
      ST_JUDGE: state_d = ST_SUM;
      ST_SUM:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  pow_judge #(
    .RecentDepth (RECENT_DEPTH)
  ) u_judge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (in_acc),
    .judge_i  (win_ctl.judge),
    .lag_i    (lag_i.lag),
    .cfg_i    (cfg_q),
    .judged_o (judged)
  );

  pow_window #(
    .WindowDepth (WINDOW_DEPTH),
    .LenW        (LW)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (win_ctl),
    .judged_i (judged),
    .len_i    (wl),
    .sum_o    (sum),
    .run_o    (run)
  );

  pow_div #(
    .LenW (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum, FRAC_W'(0)}),
    .divisor_i  (wl),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Result word: saturated Q4 average, zero while the run is too short
  assign avg_ok  = run > cfg_q.run_threshold;
  assign avg_sat = (quot[DVD_W-1:AVG_W] != '0) ? AVG_MAX : quot[AVG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q     <= avg_ok ? avg_sat : '0;
      avg_vld_q <= avg_ok;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.average_q4    = avg_q;
  assign res_o.average_valid = avg_vld_q;

`ifndef SYNTHESIS
  a_zero_when_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.average_valid |-> res_o.average_q4 == '0)
    else $error("average not zero on an invalid result");

  a_div_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_accept_to_judge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_JUDGE)
    else $error("accepted lag not judged next cycle");

  a_result_after_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == ST_DIV && !$past(div_busy))
    else $error("result loaded before divider finished");
`endif

endmodule
